// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LLRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LLRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked during reset.
`define LLRC_ASSERT_NXT_ANY(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/llrc_pkg.sv =====
// ----------------------------------------------------------------------------
// llrc_pkg
// Types, codes and constants shared by the line ring capture modules.
// ----------------------------------------------------------------------------
package llrc_pkg;

  localparam int KIND_W = 2;
  localparam int BYTE_W = 8;
  localparam int BACK_W = 6;
  localparam int COL_W  = 8;
  localparam int LEN_W  = 8;
  localparam int CNT_W  = 6;

  localparam int APB_DW      = 32;
  localparam int APB_AW      = 3;
  localparam int REG_IDX_LSB = 2;

  localparam logic REG_SHOW_LIMIT = 1'b0;

  localparam logic [CNT_W-1:0] SHOW_LIMIT_RST = 6'd10;

  localparam logic [BYTE_W-1:0] CH_NEWLINE  = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_TAB      = 8'h09;
  localparam logic [BYTE_W-1:0] CH_PRINT_LO = 8'h20;
  localparam logic [BYTE_W-1:0] CH_DEL      = 8'h7F;
  localparam logic [BYTE_W-1:0] CH_DOT      = 8'h2E;

  localparam int Q_DEPTH = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH = 2'd0,
    KIND_END  = 2'd1,
    KIND_READ = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OP_CHAR,
    OP_NEWLINE,
    OP_END,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;
    logic [BACK_W-1:0] back;
  } ent_t;

  typedef struct packed {
    logic [BYTE_W-1:0] char_out;
    logic              past_end;
    logic [LEN_W-1:0]  line_length;
    logic [CNT_W-1:0]  lines_held;
    logic [CNT_W-1:0]  lines_to_show;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_RESOLVE
  } bk_state_t;

  function automatic logic [BYTE_W-1:0] sanitize(input logic [BYTE_W-1:0] c);
    if (c == CH_TAB || (c >= CH_PRINT_LO && c < CH_DEL)) begin
      return c;
    end
    return CH_DOT;
  endfunction

endpackage

// ===== src/llrc_queue.sv =====
// ----------------------------------------------------------------------------
// llrc_queue
// Two-entry queue of classified transactions between front and back.
// ----------------------------------------------------------------------------
module llrc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  llrc_pkg::ent_t din,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output llrc_pkg::ent_t dout
);

  localparam int PtrW = $clog2(llrc_pkg::Q_DEPTH);
  localparam int CntW = $clog2(llrc_pkg::Q_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(llrc_pkg::Q_DEPTH);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(llrc_pkg::Q_DEPTH - 1);

  llrc_pkg::ent_t  q_mem_r [llrc_pkg::Q_DEPTH];
  logic [PtrW-1:0] wp_r, wp_nxt;
  logic [PtrW-1:0] rp_r, rp_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full  = (cnt_r == CntFull);
  assign valid = (cnt_r != '0);
  assign dout  = q_mem_r[rp_r];

  always_comb begin
    do_push = push && !full;
    do_pop  = pop && valid;
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PtrLast) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PtrLast) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wp_r] <= din;
    end
  end

endmodule

// ===== src/llrc_front.sv =====
// ----------------------------------------------------------------------------
// llrc_front
// Accepts input transactions, classifies and sanitizes them for the queue,
// and holds the configuration register behind the APB-style port.
// ----------------------------------------------------------------------------
module llrc_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [llrc_pkg::KIND_W-1:0]          in_kind,
  input  logic [llrc_pkg::BYTE_W-1:0]          in_byte_value,
  input  logic [llrc_pkg::BACK_W-1:0]          in_line_back,
  input  logic [llrc_pkg::COL_W-1:0]           in_column,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [llrc_pkg::APB_AW-1:0]          cfg_paddr,
  input  logic [llrc_pkg::APB_DW-1:0]          cfg_pwdata,
  output logic [llrc_pkg::APB_DW-1:0]          cfg_prdata,
  output logic                                 cfg_pready,
  input  logic                                 q_full,
  output logic                                 q_push,
  output llrc_pkg::ent_t                       q_din,
  output logic [llrc_pkg::CNT_W-1:0]           show_limit
);

  logic [llrc_pkg::CNT_W-1:0] show_limit_r;
  logic                       reg_sel;
  logic                       cfg_wr;

  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[llrc_pkg::REG_IDX_LSB] == llrc_pkg::REG_SHOW_LIMIT);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = reg_sel
                    ? {{(llrc_pkg::APB_DW - llrc_pkg::CNT_W){1'b0}}, show_limit_r}
                    : '0;
  assign show_limit = show_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      show_limit_r <= llrc_pkg::SHOW_LIMIT_RST;
    end else if (cfg_wr && reg_sel) begin
      show_limit_r <= cfg_pwdata[llrc_pkg::CNT_W-1:0];
    end
  end

  assign in_stall = q_full;

  always_comb begin
    q_push     = 1'b0;
    q_din.op   = llrc_pkg::OP_CHAR;
    q_din.data = in_byte_value;
    q_din.back = in_line_back;
    case (in_kind)
      llrc_pkg::KIND_PUSH: begin
        q_push = in_valid && !q_full;
        if (in_byte_value == llrc_pkg::CH_NEWLINE) begin
          q_din.op = llrc_pkg::OP_NEWLINE;
        end else begin
          q_din.data = llrc_pkg::sanitize(in_byte_value);
        end
      end
      llrc_pkg::KIND_END: begin
        q_push   = in_valid && !q_full;
        q_din.op = llrc_pkg::OP_END;
      end
      llrc_pkg::KIND_READ: begin
        q_push     = in_valid && !q_full;
        q_din.op   = llrc_pkg::OP_READ;
        q_din.data = in_column;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/llrc_back.sv =====
// ----------------------------------------------------------------------------
// llrc_back
// Executes queued transactions against the line ring: stores characters,
// closes lines, answers reads and end-of-stream transactions and holds the result register.
// ----------------------------------------------------------------------------
module llrc_back #(
  parameter int LINES      = 32,
  parameter int LINE_BYTES = 200
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  llrc_pkg::ent_t             q_dout,
  output logic                       q_pop,
  input  logic [llrc_pkg::CNT_W-1:0] show_limit,
  output logic                       out_valid,
  input  logic                       out_stall,
  output llrc_pkg::res_t             out_res
);

  localparam int SlotW      = $clog2(LINES);
  localparam int HeldW      = $clog2(LINES + 1);
  localparam int CntW       = (HeldW > llrc_pkg::CNT_W) ? HeldW : llrc_pkg::CNT_W;
  localparam int StoreDepth = LINES * LINE_BYTES;
  localparam int StAw       = $clog2(StoreDepth);
  localparam int SumW       = $clog2(StoreDepth + 256);
  localparam int DiffW      = $clog2(LINES + 64) + 1;

  localparam logic [SlotW-1:0]          LastSlot = SlotW'(LINES - 1);
  localparam logic [HeldW-1:0]          HeldMax  = HeldW'(LINES);
  localparam logic [CntW-1:0]           LinesCnt = CntW'(LINES);
  localparam logic [DiffW-1:0]          LinesDif = DiffW'(LINES);
  localparam logic [llrc_pkg::COL_W-1:0] ColLimit = llrc_pkg::COL_W'(LINE_BYTES - 1);
  localparam logic [StAw-1:0]           LineStep = StAw'(LINE_BYTES);
  localparam logic [SumW-1:0]           LineMul  = SumW'(LINE_BYTES);

  logic [llrc_pkg::BYTE_W-1:0] store_mem [StoreDepth];
  logic [llrc_pkg::LEN_W-1:0]  len_mem   [LINES];

  llrc_pkg::bk_state_t          state_r, state_nxt;
  logic [SlotW-1:0]             ws_r, ws_nxt;
  logic [StAw-1:0]              base_r, base_nxt;
  logic [HeldW-1:0]             held_r, held_nxt;
  logic [llrc_pkg::COL_W-1:0]   col_r, col_nxt;
  logic                         out_valid_r, out_valid_nxt;
  llrc_pkg::res_t               out_res_r, out_res_nxt;
  logic [SlotW-1:0]             rd_slot_r;
  logic [llrc_pkg::COL_W-1:0]   rd_col_r;
  logic                         rd_hit_r;
  logic [llrc_pkg::LEN_W-1:0]   len_q_r;
  logic [llrc_pkg::BYTE_W-1:0]  chr_q_r;

  logic                         store_we;
  logic                         close_line;
  logic                         rd_capture;
  logic                         out_load;
  logic                         out_free;
  logic [DiffW-1:0]             slot_diff;
  logic [SlotW-1:0]             slot_calc;
  logic                         hit_calc;
  logic [HeldW-1:0]             held_inc;
  logic [CntW-1:0]              held_ext;
  logic [CntW-1:0]              lim_ext;
  logic [CntW-1:0]              show_ext;
  logic [SumW-1:0]              wr_addr;
  logic [SumW-1:0]              rd_addr;
  logic                         rd_past;

  assign out_free  = !out_valid_r || !out_stall;
  assign slot_diff = DiffW'(ws_r) + LinesDif - DiffW'(q_dout.back);
  assign slot_calc = (slot_diff >= LinesDif) ? SlotW'(slot_diff - LinesDif) : SlotW'(slot_diff);
  assign hit_calc  = (q_dout.back != '0) && (CntW'(q_dout.back) <= CntW'(held_r));
  assign held_inc  = (held_r != HeldMax) ? held_r + 1'b1 : held_r;
  assign wr_addr   = SumW'(base_r) + SumW'(col_r);
  assign rd_addr   = SumW'(rd_slot_r) * LineMul + SumW'(rd_col_r);
  assign rd_past   = !rd_hit_r || (rd_col_r >= len_q_r);

  always_comb begin
    lim_ext  = (CntW'(show_limit) > LinesCnt) ? LinesCnt : CntW'(show_limit);
    held_ext = CntW'(held_nxt);
    show_ext = (lim_ext < held_ext) ? lim_ext : held_ext;
  end

  always_comb begin
    state_nxt  = state_r;
    q_pop      = 1'b0;
    store_we   = 1'b0;
    close_line = 1'b0;
    rd_capture = 1'b0;
    out_load   = 1'b0;
    col_nxt    = col_r;
    case (state_r)
      llrc_pkg::BK_IDLE: begin
        if (q_valid) begin
          case (q_dout.op)
            llrc_pkg::OP_CHAR: begin
              q_pop = 1'b1;
              if (col_r < ColLimit) begin
                store_we = 1'b1;
                col_nxt  = col_r + 1'b1;
              end
            end
            llrc_pkg::OP_NEWLINE: begin
              q_pop      = 1'b1;
              close_line = 1'b1;
            end
            llrc_pkg::OP_END: begin
              if (out_free) begin
                q_pop      = 1'b1;
                out_load   = 1'b1;
                close_line = (col_r != '0);
              end
            end
            llrc_pkg::OP_READ: begin
              if (out_free) begin
                q_pop      = 1'b1;
                rd_capture = 1'b1;
                state_nxt  = llrc_pkg::BK_FETCH;
              end
            end
            default: begin
              q_pop = 1'b0;
            end
          endcase
        end
      end
      llrc_pkg::BK_FETCH: begin
        state_nxt = llrc_pkg::BK_RESOLVE;
      end
      llrc_pkg::BK_RESOLVE: begin
        out_load  = 1'b1;
        state_nxt = llrc_pkg::BK_IDLE;
      end
      default: begin
        state_nxt = llrc_pkg::BK_IDLE;
      end
    endcase

    ws_nxt   = ws_r;
    base_nxt = base_r;
    held_nxt = held_r;
    if (close_line) begin
      ws_nxt   = (ws_r == LastSlot) ? '0 : ws_r + 1'b1;
      base_nxt = (ws_r == LastSlot) ? '0 : base_r + LineStep;
      held_nxt = held_inc;
      col_nxt  = '0;
    end
  end

  always_comb begin
    out_res_nxt.lines_held    = held_ext[llrc_pkg::CNT_W-1:0];
    out_res_nxt.lines_to_show = show_ext[llrc_pkg::CNT_W-1:0];
    if (state_r == llrc_pkg::BK_RESOLVE) begin
      out_res_nxt.past_end    = rd_past;
      out_res_nxt.line_length = rd_hit_r ? len_q_r : '0;
      out_res_nxt.char_out    = rd_past ? '0 : chr_q_r;
    end else begin
      out_res_nxt.past_end    = 1'b0;
      out_res_nxt.line_length = '0;
      out_res_nxt.char_out    = '0;
    end
    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= llrc_pkg::BK_IDLE;
      ws_r        <= '0;
      base_r      <= '0;
      held_r      <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ws_r        <= ws_nxt;
      base_r      <= base_nxt;
      held_r      <= held_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= out_res_nxt;
    end
    if (rd_capture) begin
      rd_slot_r <= slot_calc;
      rd_col_r  <= q_dout.data;
      rd_hit_r  <= hit_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[wr_addr[StAw-1:0]] <= q_dout.data;
    end
    if (state_r == llrc_pkg::BK_FETCH) begin
      chr_q_r <= store_mem[rd_addr[StAw-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (close_line) begin
      len_mem[ws_r] <= col_r;
    end
    if (state_r == llrc_pkg::BK_FETCH) begin
      len_q_r <= len_mem[rd_slot_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ===== src/last_lines_ring_capture.sv =====
// ----------------------------------------------------------------------------
// last_lines_ring_capture
// Keeps the last LINES text lines of a byte stream in a ring and answers
// end-of-stream and character read transactions.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake           Payload
//   in_      input      in_valid/in_stall   kind, byte_value, line_back, column
//   out_     output     out_valid/out_stall char_out, past_end, line_length,
//                                           lines_held, lines_to_show
//   cfg_     input      APB-style access    show_limit at byte address 0
//
// In the back end, byte pushes, newlines and end-of-stream execute in the idle
// state; a character read computes its slot there, then does a registered read
// of the line store and length memory and finally forms the result.
// A two-entry queue separates input acceptance from execution.
// After reset the line store holds no defined data and is not cleared; only
// closed lines are ever read. A stalled result holds the back end at the next
// transaction that produces a result; byte pushes queued ahead of it still
// execute, and once the queue is full the input stalls.
// ----------------------------------------------------------------------------
module last_lines_ring_capture #(
  parameter int LINES      = 32,
  parameter int LINE_BYTES = 200
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [llrc_pkg::KIND_W-1:0] in_kind,
  input  logic [llrc_pkg::BYTE_W-1:0] in_byte_value,
  input  logic [llrc_pkg::BACK_W-1:0] in_line_back,
  input  logic [llrc_pkg::COL_W-1:0]  in_column,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [llrc_pkg::BYTE_W-1:0] out_char_out,
  output logic                        out_past_end,
  output logic [llrc_pkg::LEN_W-1:0]  out_line_length,
  output logic [llrc_pkg::CNT_W-1:0]  out_lines_held,
  output logic [llrc_pkg::CNT_W-1:0]  out_lines_to_show,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [llrc_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [llrc_pkg::APB_DW-1:0] cfg_pwdata,
  output logic [llrc_pkg::APB_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  logic                       q_full;
  logic                       q_push;
  llrc_pkg::ent_t             q_din;
  logic                       q_pop;
  logic                       q_valid;
  llrc_pkg::ent_t             q_dout;
  logic [llrc_pkg::CNT_W-1:0] show_limit;
  llrc_pkg::res_t             out_res;

  llrc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_byte_value (in_byte_value),
    .in_line_back  (in_line_back),
    .in_column     (in_column),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_din         (q_din),
    .show_limit    (show_limit)
  );

  llrc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  llrc_back #(
    .LINES      (LINES),
    .LINE_BYTES (LINE_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_dout     (q_dout),
    .q_pop      (q_pop),
    .show_limit (show_limit),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  assign out_char_out      = out_res.char_out;
  assign out_past_end      = out_res.past_end;
  assign out_line_length   = out_res.line_length;
  assign out_lines_held    = out_res.lines_held;
  assign out_lines_to_show = out_res.lines_to_show;

endmodule

// ===== src/llrc_checker.sv =====
// ----------------------------------------------------------------------------
// llrc_checker
// Port-level checks on the result channel of the line ring capture block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module llrc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [llrc_pkg::BYTE_W-1:0] out_char_out,
  input logic                        out_past_end,
  input logic [llrc_pkg::LEN_W-1:0]  out_line_length
);

  `LLRC_ASSERT_IMP(a_past_zero, clk, rst_n, out_valid && out_past_end, out_char_out == '0)
  `LLRC_ASSERT_IMP(a_hit_char, clk, rst_n, out_valid && !out_past_end && out_line_length != '0, out_char_out != '0)
  `LLRC_ASSERT_IMP(a_nolen_zero, clk, rst_n, out_valid && out_line_length == '0, out_char_out == '0)
  `LLRC_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `LLRC_ASSERT_NXT_ANY(a_reset_idle, clk, !rst_n, !out_valid)

endmodule

bind last_lines_ring_capture llrc_checker u_llrc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_char_out    (out_char_out),
  .out_past_end    (out_past_end),
  .out_line_length (out_line_length)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for last_lines_ring_capture. A short directed sequence
// covers the field extremes, the unused kind, empty and partial lines and
// reads outside the held lines, followed by random streams of text lines
// mixed with reads and end-of-stream transactions under several show_limit
// settings. Every reply is compared field by field against a behavioral
// ring copy or a directed expected value. Both channels idle and stall in
// random bursts, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINES      = 32;
  localparam int LINE_BYTES = 200;
  localparam int SETTLE_CYC = 24;
  localparam int HOLD_CYC   = 300;
  localparam int PHASES     = 5;
  localparam int PHASE_ITEMS = 240;
  localparam logic [llrc_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [llrc_pkg::KIND_W-1:0] kind;
    logic [llrc_pkg::BYTE_W-1:0] byte_value;
    logic [llrc_pkg::BACK_W-1:0] line_back;
    logic [llrc_pkg::COL_W-1:0]  column;
    bit                          typed;
    llrc_pkg::res_t              want;
  } step_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [llrc_pkg::KIND_W-1:0]   in_kind;
  logic [llrc_pkg::BYTE_W-1:0]   in_byte_value;
  logic [llrc_pkg::BACK_W-1:0]   in_line_back;
  logic [llrc_pkg::COL_W-1:0]    in_column;
  logic                          out_valid;
  logic                          out_stall;
  logic [llrc_pkg::BYTE_W-1:0]   out_char_out;
  logic                          out_past_end;
  logic [llrc_pkg::LEN_W-1:0]    out_line_length;
  logic [llrc_pkg::CNT_W-1:0]    out_lines_held;
  logic [llrc_pkg::CNT_W-1:0]    out_lines_to_show;
  logic                          cfg_psel;
  logic                          cfg_penable;
  logic                          cfg_pwrite;
  logic [llrc_pkg::APB_AW-1:0]   cfg_paddr;
  logic [llrc_pkg::APB_DW-1:0]   cfg_pwdata;
  logic [llrc_pkg::APB_DW-1:0]   cfg_prdata;
  logic                          cfg_pready;

  logic [llrc_pkg::BYTE_W-1:0] ring_text [LINES][LINE_BYTES];
  int                          ring_len  [LINES];
  int                          wr_slot;
  int                          lines_kept;
  int                          cur_col;
  int                          shown_limit;

  llrc_pkg::res_t due_replies[$];
  step_t          steps[$];

  int  err_count;
  int  n_push, n_end, n_read, n_ignored, n_checked, n_settings;
  bit  quiet;
  bit  hold_req;
  bit  hold_done;

  last_lines_ring_capture #(
    .LINES      (LINES),
    .LINE_BYTES (LINE_BYTES)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_byte_value     (in_byte_value),
    .in_line_back      (in_line_back),
    .in_column         (in_column),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_char_out      (out_char_out),
    .out_past_end      (out_past_end),
    .out_line_length   (out_line_length),
    .out_lines_held    (out_lines_held),
    .out_lines_to_show (out_lines_to_show),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic logic [llrc_pkg::BYTE_W-1:0] printable(
      input logic [llrc_pkg::BYTE_W-1:0] c);
    if (c == llrc_pkg::CH_TAB || (c >= llrc_pkg::CH_PRINT_LO && c < llrc_pkg::CH_DEL)) begin
      return c;
    end
    return llrc_pkg::CH_DOT;
  endfunction

  function automatic void close_line();
    ring_len[wr_slot] = cur_col;
    wr_slot = (wr_slot + 1) % LINES;
    if (lines_kept < LINES) begin
      lines_kept++;
    end
    cur_col = 0;
  endfunction

  function automatic llrc_pkg::res_t mk_res(input logic [llrc_pkg::BYTE_W-1:0] ch,
                                            input logic past,
                                            input logic [llrc_pkg::LEN_W-1:0] len,
                                            input logic [llrc_pkg::CNT_W-1:0] held,
                                            input logic [llrc_pkg::CNT_W-1:0] show);
    llrc_pkg::res_t r;
    r.char_out      = ch;
    r.past_end      = past;
    r.line_length   = len;
    r.lines_held    = held;
    r.lines_to_show = show;
    return r;
  endfunction

  // Advances the bench's copy of the ring by one transaction and returns 1
  // when the transaction produces a reply.
  function automatic bit capture_step(input logic [llrc_pkg::KIND_W-1:0] k,
                                      input logic [llrc_pkg::BYTE_W-1:0] b,
                                      input logic [llrc_pkg::BACK_W-1:0] back,
                                      input logic [llrc_pkg::COL_W-1:0] col,
                                      output llrc_pkg::res_t r);
    int slot;
    int lim;
    r = '0;
    case (k)
      llrc_pkg::KIND_PUSH: begin
        if (b == llrc_pkg::CH_NEWLINE) begin
          close_line();
        end else if (cur_col < LINE_BYTES - 1) begin
          ring_text[wr_slot][cur_col] = printable(b);
          cur_col++;
        end
        return 1'b0;
      end
      llrc_pkg::KIND_END: begin
        if (cur_col > 0) begin
          close_line();
        end
      end
      llrc_pkg::KIND_READ: begin
        if (back == 0 || int'(back) > lines_kept) begin
          r.past_end = 1'b1;
        end else begin
          slot = (wr_slot + LINES - int'(back)) % LINES;
          r.line_length = llrc_pkg::LEN_W'(ring_len[slot]);
          if (int'(col) >= ring_len[slot]) begin
            r.past_end = 1'b1;
          end else begin
            r.char_out = ring_text[slot][col];
          end
        end
      end
      default: begin
        return 1'b0;
      end
    endcase
    lim = shown_limit < LINES ? shown_limit : LINES;
    r.lines_held    = llrc_pkg::CNT_W'(lines_kept);
    r.lines_to_show = llrc_pkg::CNT_W'(lim < lines_kept ? lim : lines_kept);
    return 1'b1;
  endfunction

  function automatic void add_step(input logic [llrc_pkg::KIND_W-1:0] k,
                                   input logic [llrc_pkg::BYTE_W-1:0] b,
                                   input logic [llrc_pkg::BACK_W-1:0] back,
                                   input logic [llrc_pkg::COL_W-1:0] col,
                                   input bit typed, input llrc_pkg::res_t want);
    step_t s;
    s.kind       = k;
    s.byte_value = b;
    s.line_back  = back;
    s.column     = col;
    s.typed      = typed;
    s.want       = want;
    steps.push_back(s);
  endfunction

  task automatic cmp_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: mismatch on %s: expected %0d (0x%0h), actual %0d (0x%0h)",
               $time, name, want, want, got, got);
      err_count++;
    end
  endtask

  task automatic offer(input logic [llrc_pkg::KIND_W-1:0] k,
                       input logic [llrc_pkg::BYTE_W-1:0] b,
                       input logic [llrc_pkg::BACK_W-1:0] back,
                       input logic [llrc_pkg::COL_W-1:0] col,
                       input bit typed, input llrc_pkg::res_t want);
    llrc_pkg::res_t r;
    bit             gives;
    if (!quiet && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= k;
    in_byte_value <= b;
    in_line_back  <= back;
    in_column     <= col;
    do @(posedge clk); while (in_stall);
    gives = capture_step(k, b, back, col, r);
    if (gives) begin
      due_replies.push_back(typed ? want : r);
    end
    case (k)
      llrc_pkg::KIND_PUSH: n_push++;
      llrc_pkg::KIND_END:  n_end++;
      llrc_pkg::KIND_READ: n_read++;
      default:             n_ignored++;
    endcase
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_limit(input logic [llrc_pkg::APB_DW-1:0] value);
    logic [llrc_pkg::APB_DW-1:0] readback;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= llrc_pkg::APB_AW'(llrc_pkg::REG_SHOW_LIMIT) << llrc_pkg::REG_IDX_LSB;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    shown_limit = int'(value[llrc_pkg::CNT_W-1:0]);
    n_settings++;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    readback = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cmp_field("show_limit readback", shown_limit, int'(readback));
  endtask

  initial begin : result_sink
    int             hold_left;
    int             stall_left;
    llrc_pkg::res_t want;
    hold_left  = 0;
    stall_left = 0;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        n_checked++;
        if (due_replies.size() == 0) begin
          $display("%0t: reply with nothing expected: char %0h past_end %0d len %0d",
                   $time, out_char_out, out_past_end, out_line_length);
          err_count++;
        end else begin
          want = due_replies.pop_front();
          cmp_field("char_out", int'(want.char_out), int'(out_char_out));
          cmp_field("past_end", int'(want.past_end), int'(out_past_end));
          cmp_field("line_length", int'(want.line_length), int'(out_line_length));
          cmp_field("lines_held", int'(want.lines_held), int'(out_lines_held));
          cmp_field("lines_to_show", int'(want.lines_to_show), int'(out_lines_to_show));
        end
      end
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYC;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < 8) begin
        stall_left = $urandom_range(0, 15);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    logic [llrc_pkg::APB_DW-1:0] limits [PHASES];
    int                          phase_items;
    int                          pick;
    int                          len;
    int                          back;
    int                          slot;
    int                          known_len;
    logic [llrc_pkg::BYTE_W-1:0] b;

    err_count = 0;
    n_push = 0; n_end = 0; n_read = 0; n_ignored = 0; n_checked = 0; n_settings = 0;
    quiet = 1'b0; hold_req = 1'b0; hold_done = 1'b0;
    foreach (ring_len[i]) ring_len[i] = 0;
    wr_slot = 0; lines_kept = 0; cur_col = 0;
    shown_limit = int'(llrc_pkg::SHOW_LIMIT_RST);

    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_kind       <= llrc_pkg::KIND_PUSH;
    in_byte_value <= '0;
    in_line_back  <= '0;
    in_column     <= '0;
    cfg_psel      <= 1'b0;
    cfg_penable   <= 1'b0;
    cfg_pwrite    <= 1'b0;
    cfg_paddr     <= '0;
    cfg_pwdata    <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_step(llrc_pkg::KIND_READ, 8'h00, 6'd1, 8'd0, 1'b1,
             mk_res(8'h00, 1'b1, 8'd0, 6'd0, 6'd0));
    add_step(llrc_pkg::KIND_END, 8'h00, 6'd0, 8'd0, 1'b1,
             mk_res(8'h00, 1'b0, 8'd0, 6'd0, 6'd0));
    add_step(KIND_UNUSED, 8'hFF, 6'd63, 8'd255, 1'b0, '0);
    add_step(llrc_pkg::KIND_PUSH, 8'h41, 6'd0, 8'd0, 1'b0, '0);
    add_step(llrc_pkg::KIND_PUSH, llrc_pkg::CH_TAB, 6'd0, 8'd0, 1'b0, '0);
    add_step(llrc_pkg::KIND_PUSH, 8'h00, 6'd0, 8'd0, 1'b0, '0);
    add_step(llrc_pkg::KIND_PUSH, llrc_pkg::CH_DEL, 6'd0, 8'd0, 1'b0, '0);
    add_step(llrc_pkg::KIND_PUSH, 8'hFF, 6'd63, 8'd255, 1'b0, '0);
    add_step(llrc_pkg::KIND_PUSH, 8'h7E, 6'd0, 8'd0, 1'b0, '0);
    add_step(llrc_pkg::KIND_PUSH, llrc_pkg::CH_PRINT_LO, 6'd0, 8'd0, 1'b0, '0);
    add_step(llrc_pkg::KIND_PUSH, 8'h1F, 6'd0, 8'd0, 1'b0, '0);
    add_step(llrc_pkg::KIND_PUSH, llrc_pkg::CH_NEWLINE, 6'd0, 8'd0, 1'b0, '0);
    add_step(llrc_pkg::KIND_READ, 8'h00, 6'd1, 8'd0, 1'b0, '0);
    add_step(llrc_pkg::KIND_READ, 8'h00, 6'd1, 8'd2, 1'b0, '0);
    add_step(llrc_pkg::KIND_READ, 8'h00, 6'd1, 8'd7, 1'b0, '0);
    add_step(llrc_pkg::KIND_READ, 8'h00, 6'd1, 8'd8, 1'b1,
             mk_res(8'h00, 1'b1, 8'd8, 6'd1, 6'd1));
    add_step(llrc_pkg::KIND_READ, 8'h00, 6'd0, 8'd0, 1'b1,
             mk_res(8'h00, 1'b1, 8'd0, 6'd1, 6'd1));
    add_step(llrc_pkg::KIND_READ, 8'hFF, 6'd63, 8'd255, 1'b1,
             mk_res(8'h00, 1'b1, 8'd0, 6'd1, 6'd1));
    add_step(llrc_pkg::KIND_PUSH, 8'h78, 6'd0, 8'd0, 1'b0, '0);
    add_step(llrc_pkg::KIND_READ, 8'h00, 6'd1, 8'd0, 1'b0, '0);
    add_step(llrc_pkg::KIND_END, 8'h00, 6'd0, 8'd0, 1'b1,
             mk_res(8'h00, 1'b0, 8'd0, 6'd2, 6'd2));
    add_step(llrc_pkg::KIND_END, 8'h00, 6'd0, 8'd0, 1'b1,
             mk_res(8'h00, 1'b0, 8'd0, 6'd2, 6'd2));
    add_step(llrc_pkg::KIND_READ, 8'h00, 6'd2, 8'd1, 1'b0, '0);
    add_step(llrc_pkg::KIND_READ, 8'h00, 6'd1, 8'd0, 1'b0, '0);
    foreach (steps[i]) begin
      offer(steps[i].kind, steps[i].byte_value, steps[i].line_back, steps[i].column,
            steps[i].typed, steps[i].want);
    end

    limits[0] = 32'd0;
    limits[1] = 32'd32;
    limits[2] = 32'hA5A5_A5FF;
    limits[3] = 32'd7;
    limits[4] = $urandom;
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_limit(limits[p]);
      hold_req = (p == 1);
      quiet    = (p == PHASES - 1);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          len = $urandom_range(0, 24);
          if ($urandom_range(0, 99) < 5) begin
            len = $urandom_range(190, 230);
          end else if ($urandom_range(0, 99) < 4) begin
            len = $urandom_range(0, LINE_BYTES - 1);
          end
          for (int j = 0; j < len; j++) begin
            b = ($urandom_range(0, 99) < 70) ? llrc_pkg::BYTE_W'($urandom_range(32, 126))
                                             : llrc_pkg::BYTE_W'($urandom_range(0, 255));
            offer(llrc_pkg::KIND_PUSH, b, llrc_pkg::BACK_W'($urandom),
                  llrc_pkg::COL_W'($urandom), 1'b0, '0);
            phase_items++;
          end
          if ($urandom_range(0, 99) < 90) begin
            offer(llrc_pkg::KIND_PUSH, llrc_pkg::CH_NEWLINE, llrc_pkg::BACK_W'($urandom),
                  llrc_pkg::COL_W'($urandom), 1'b0, '0);
            phase_items++;
          end
        end else if (pick < 85) begin
          if ($urandom_range(0, 99) < 85) begin
            back = $urandom_range(1, lines_kept + 1);
          end else begin
            back = $urandom_range(0, 63);
          end
          known_len = 0;
          if (back >= 1 && back <= lines_kept) begin
            slot = (wr_slot + LINES - back) % LINES;
            known_len = ring_len[slot];
          end
          offer(llrc_pkg::KIND_READ, llrc_pkg::BYTE_W'($urandom), llrc_pkg::BACK_W'(back),
                ($urandom_range(0, 99) < 80)
                  ? llrc_pkg::COL_W'($urandom_range(0, known_len + 2))
                  : llrc_pkg::COL_W'($urandom_range(0, 255)),
                1'b0, '0);
          phase_items++;
        end else if (pick < 93) begin
          offer(llrc_pkg::KIND_END, llrc_pkg::BYTE_W'($urandom), llrc_pkg::BACK_W'($urandom),
                llrc_pkg::COL_W'($urandom), 1'b0, '0);
          phase_items++;
        end else if (pick < 97) begin
          offer(KIND_UNUSED, llrc_pkg::BYTE_W'($urandom), llrc_pkg::BACK_W'($urandom),
                llrc_pkg::COL_W'($urandom), 1'b0, '0);
        end else begin
          offer(llrc_pkg::KIND_PUSH, llrc_pkg::BYTE_W'($urandom), llrc_pkg::BACK_W'($urandom),
                llrc_pkg::COL_W'($urandom), 1'b0, '0);
          phase_items++;
        end
      end
    end

    settle();
    repeat (32) @(posedge clk);
    $display("run covered %0d pushes, %0d end-of-stream and %0d read transactions",
             n_push, n_end, n_read);
    $display("plus %0d ignored; %0d replies checked over %0d show_limit settings",
             n_ignored, n_checked, n_settings);
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== last_lines_ring_capture.f =====
+incdir+src
src/llrc_pkg.sv
src/llrc_queue.sv
src/llrc_front.sv
src/llrc_back.sv
src/last_lines_ring_capture.sv
src/llrc_checker.sv
tb/testbench.sv
